// File: rtl/core/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared sizes, codes and the entry type of the top-k score keeper.
// ----------------------------------------------------------------------------
package tks_pkg;

  // list and field sizes
  localparam int MAX_KEEP   = 16;
  localparam int ID_BITS    = 16;
  localparam int SCORE_BITS = 32;
  localparam int ADDR_W     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);
  localparam int RANK_W     = 4;
  localparam int KEEP_W     = 5;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // action codes of an input word
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LARGEST = 2'd1;

  // one held list entry
  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic        [ID_BITS-1:0]    id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/tks_ram.sv
// ----------------------------------------------------------------------------
// tks_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tks_rank_cmp.sv
// ----------------------------------------------------------------------------
// tks_rank_cmp
// Shared rank comparator: tells whether a held score ranks at or ahead of a
// new score under the current sort direction.
// ----------------------------------------------------------------------------
module tks_rank_cmp
  import tks_pkg::*;
(
  input  logic signed [SCORE_BITS-1:0] held_score_i,
  input  logic signed [SCORE_BITS-1:0] new_score_i,
  input  logic                         keep_largest_i,
  output logic                         ranks_before_o
);

  logic held_ge_new;
  logic held_le_new;

  // signed magnitude compares, one for each direction
  assign held_ge_new = (held_score_i >= new_score_i);
  assign held_le_new = (held_score_i <= new_score_i);

  // ties keep the held entry ahead
  assign ranks_before_o = keep_largest_i ? held_ge_new : held_le_new;

endmodule

// File: rtl/core/top_k_score_keeper_top.sv
// ----------------------------------------------------------------------------
// top_k_score_keeper_top
// Keeps the best scored items sorted in rank order and reads them out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: action, item_id
//   and score. Insert places the item at its rank, read-out emits the held
//   list best first on the output channel (out_valid_o / out_stall_i) with
//   last_o on the final word, or one word with empty_res_o set when the list
//   is empty. Clear empties the list. The config port writes keep_count and
//   keep_largest; a change of sort direction empties the list.
//   Timing: the list sits in a RAM with a registered read, and one shared
//   comparator walks it from the tail. An insert into an empty list is
//   written at once; otherwise each entry that ranks behind the new word
//   is shifted one rank down until its slot is found, a full list first
//   checking its tail entry. A read-out emits one word per cycle while the
//   receiver is free. Clear and unused actions do not stall the input.
//   in_stall_o is high while an action is in progress. A finished word waits
//   in the output register while out_stall_i is high; a new input word is
//   still taken meanwhile, and a following read-out waits for the register.
//   Reset empties the list and restores keep_count 16 and keep_largest 1.
// ----------------------------------------------------------------------------
module top_k_score_keeper_top
  import tks_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ACT_W-1:0]             action_i,
  input  logic [ID_BITS-1:0]           item_id_i,
  input  logic signed [SCORE_BITS-1:0] score_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [RANK_W-1:0]            rank_o,
  output logic [ID_BITS-1:0]           out_id_o,
  output logic signed [SCORE_BITS-1:0] out_score_o,
  output logic                         last_o,
  output logic                         empty_res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_RD_LOAD,
    ST_RD_EMPTY
  } state_e;

  // clamp keep_count into 1..MAX_KEEP
  function automatic logic [CNT_W-1:0] eff_keep(input logic [KEEP_W-1:0] kc);
    logic [CNT_W-1:0] r;
    if (kc == '0) begin
      r = CNT_W'(1);
    end else if (int'(kc) > MAX_KEEP) begin
      r = CNT_W'(MAX_KEEP);
    end else begin
      r = CNT_W'(kc);
    end
    return r;
  endfunction

  state_e               state_q, state_d;
  logic [KEEP_W-1:0]    keep_count_q, keep_count_d;
  logic                 keep_largest_q, keep_largest_d;
  logic [CNT_W-1:0]     held_q, held_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic                 full_q, full_d;
  entry_t               new_q, new_d;

  logic                 out_valid_q, out_valid_d;
  logic [RANK_W-1:0]    rank_q, rank_d;
  entry_t               out_q, out_d;
  logic                 last_q, last_d;
  logic                 empty_q, empty_d;

  logic [CNT_W-1:0]     keep_eff;
  logic                 in_acc;
  logic                 out_free;
  logic                 ranks_before;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  entry_t               ram_rdata;

  assign keep_eff   = eff_keep(keep_count_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // entry storage
  tks_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEEP)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared comparator, always against the word being inserted
  tks_rank_cmp u_cmp (
    .held_score_i   (ram_rdata.score),
    .new_score_i    (new_q.score),
    .keep_largest_i (keep_largest_q),
    .ranks_before_o (ranks_before)
  );

  // sequencer
  always_comb begin
    state_d        = state_q;
    keep_count_d   = keep_count_q;
    keep_largest_d = keep_largest_q;
    held_d         = held_q;
    idx_d          = idx_q;
    full_d         = full_q;
    new_d          = new_q;
    out_valid_d    = out_valid_q;
    rank_d         = rank_q;
    out_d          = out_q;
    last_d         = last_q;
    empty_d        = empty_q;
    ram_we         = 1'b0;
    ram_waddr      = idx_q;
    ram_wdata      = new_q;
    ram_re         = 1'b0;
    ram_raddr      = idx_q - 1'b1;

    // output word taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(action_i))
            ACT_INSERT: begin
              new_d.id    = item_id_i;
              new_d.score = score_i;
              if (held_q == keep_eff) begin
                // full list: check the tail entry first
                full_d    = 1'b1;
                idx_d     = ADDR_W'(keep_eff - 1'b1);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(keep_eff - 1'b1);
                state_d   = ST_INS_CHK;
              end else if (held_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata.id    = item_id_i;
                ram_wdata.score = score_i;
                held_d    = CNT_W'(1);
              end else begin
                full_d    = 1'b0;
                idx_d     = ADDR_W'(held_q);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(held_q - 1'b1);
                state_d   = ST_INS_CMP;
              end
            end
            ACT_READ: begin
              idx_d = '0;
              if (held_q == '0) begin
                state_d = ST_RD_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ST_RD_LOAD;
              end
            end
            ACT_CLEAR: begin
              held_d = '0;
            end
            ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      ST_INS_CHK: begin
        if (ranks_before) begin
          // new word falls past the last kept rank
          state_d = ST_IDLE;
        end else if (idx_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        if (ranks_before) begin
          // slot found behind the compared entry
          ram_we  = 1'b1;
          if (!full_q) begin
            held_d = held_q + 1'b1;
          end
          state_d = ST_IDLE;
        end else begin
          // shift the compared entry one rank down
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_d     = idx_q - 1'b1;
          if (idx_q == ADDR_W'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - ADDR_W'(2);
          end
        end
      end

      ST_INS_PUT: begin
        ram_we = 1'b1;
        if (!full_q) begin
          held_d = held_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      ST_RD_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rank_d      = RANK_W'(idx_q);
          out_d       = ram_rdata;
          empty_d     = 1'b0;
          last_d      = (idx_q == ADDR_W'(held_q - 1'b1));
          if (idx_q == ADDR_W'(held_q - 1'b1)) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_q + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_q + 1'b1;
          end
        end
      end

      ST_RD_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rank_d      = '0;
          out_d       = '0;
          last_d      = 1'b1;
          empty_d     = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // config writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEEP_COUNT: begin
          keep_count_d = cfg_data_i[KEEP_W-1:0];
          if (held_q > eff_keep(cfg_data_i[KEEP_W-1:0])) begin
            held_d = eff_keep(cfg_data_i[KEEP_W-1:0]);
          end
        end
        CFG_KEEP_LARGEST: begin
          keep_largest_d = cfg_data_i[0];
          if (cfg_data_i[0] != keep_largest_q) begin
            held_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      keep_count_q   <= KEEP_W'(16);
      keep_largest_q <= 1'b1;
      held_q         <= '0;
      idx_q          <= '0;
      full_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      keep_count_q   <= keep_count_d;
      keep_largest_q <= keep_largest_d;
      held_q         <= held_d;
      idx_q          <= idx_d;
      full_q         <= full_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    new_q   <= new_d;
    rank_q  <= rank_d;
    out_q   <= out_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign rank_o      = rank_q;
  assign out_id_o    = out_q.id;
  assign out_score_o = out_q.score;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

endmodule
